### hw/rtl/bhpq_pkg.sv
package bhpq_pkg;

   localparam int DEPTH_DEF = 256;
   localparam int KEY_W     = 32;
   localparam int TAG_W     = 16;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 9;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_RM_ROOT,
      ST_RM_LAST,
      ST_RM_MOVE,
      ST_DN_CHK,
      ST_DN_L,
      ST_DN_R,
      ST_DONE
   } state_type;

endpackage

### hw/rtl/bhpq_ram.sv
module bhpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/binary_heap_priority_queue_top.sv
// A dropped insert or a remove on an empty heap goes from idle straight to the done state.
// Insert: per level climbed, a check state reads the parent and a compare state moves it
// down into the hole, until the entry is written at the root or below a parent it does not beat.
// Remove: reads the root and the last entry, sifting it down if entries remain. One item at
// a time: a stalled result waits in done, and the next is taken the cycle after it is loaded.
// Reset clears the entry count, the order register, the controller and the result valid.
module binary_heap_priority_queue_top
   import bhpq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [TAG_W-1:0]    req_tag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KEY_W-1:0]    rsp_out_key,
   output logic [TAG_W-1:0]    rsp_out_tag,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = AW + 2;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                order_max_ff;
   entry_type           item_ff, item_in;
   entry_type           left_ff, left_in;
   entry_type           result_ff, result_in;
   status_type          status_ff, status_in;
   logic [AW-1:0]       hole_ff, hole_in;
   logic [AW-1:0]       child_ff, child_in;

   logic                rsp_valid_ff;
   entry_type           rsp_entry_ff;
   status_type          rsp_status_ff;
   logic [CW-1:0]       rsp_count_ff;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   entry_type           ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata_raw;
   entry_type           ram_rdata;

   logic                req_beat;
   logic                rsp_load;
   logic [CMPW-1:0]     child_w;
   logic [CMPW-1:0]     right_w;
   logic [CMPW-1:0]     count_w;
   entry_type           cand;
   logic [AW-1:0]       cand_idx;

   function automatic logic better(input logic [KEY_W-1:0] a,
                                   input logic [KEY_W-1:0] b,
                                   input logic             om);
      return om ? (a > b) : (a < b);
   endfunction

   bhpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = entry_type'(ram_rdata_raw);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign count_w = CMPW'(count_ff);
   assign child_w = {1'b0, hole_ff, 1'b1};
   assign right_w = CMPW'(child_ff) + CMPW'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      item_in   = item_ff;
      left_in   = left_ff;
      result_in = result_ff;
      status_in = status_ff;
      hole_in   = hole_ff;
      child_in  = child_ff;
      ram_we    = 1'b0;
      ram_waddr = hole_ff;
      ram_wdata = item_ff;
      ram_raddr = '0;
      cand      = ram_rdata;
      cand_idx  = child_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               result_in = '0;
               status_in = STATUS_OK;
               if (req_mode == MODE_INSERT) begin
                  if (count_ff >= CW'(DEPTH)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     item_in  = '{key: req_key, tag: req_tag};
                     hole_in  = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     state_in = ST_UP_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     state_in = ST_RM_ROOT;
                  end
               end
            end
         end

         ST_UP_CHK: begin
            if (hole_ff == '0) begin
               ram_we   = 1'b1;
               state_in = ST_DONE;
            end else begin
               ram_raddr = (hole_ff - AW'(1)) >> 1;
               child_in  = (hole_ff - AW'(1)) >> 1;
               state_in  = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            ram_we = 1'b1;
            if (better(item_ff.key, ram_rdata.key, order_max_ff)) begin
               // move the parent down into the hole and climb
               ram_wdata = ram_rdata;
               hole_in   = child_ff;
               state_in  = ST_UP_CHK;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_RM_ROOT: begin
            ram_raddr = '0;
            state_in  = ST_RM_LAST;
         end

         ST_RM_LAST: begin
            result_in = ram_rdata;
            ram_raddr = AW'(count_ff - CW'(1));
            count_in  = count_ff - CW'(1);
            state_in  = ST_RM_MOVE;
         end

         ST_RM_MOVE: begin
            item_in = ram_rdata;
            hole_in = '0;
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DN_CHK;
            end
         end

         ST_DN_CHK: begin
            if (child_w >= count_w) begin
               ram_we   = 1'b1;
               state_in = ST_DONE;
            end else begin
               ram_raddr = child_w[AW-1:0];
               child_in  = child_w[AW-1:0];
               state_in  = ST_DN_L;
            end
         end

         ST_DN_L: begin
            left_in = ram_rdata;
            if (right_w < count_w) begin
               ram_raddr = right_w[AW-1:0];
               state_in  = ST_DN_R;
            end else begin
               cand     = ram_rdata;
               cand_idx = child_ff;
               ram_we   = 1'b1;
               if (better(cand.key, item_ff.key, order_max_ff)) begin
                  ram_wdata = cand;
                  hole_in   = cand_idx;
                  state_in  = ST_DN_CHK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DN_R: begin
            // take the right child only when strictly better than the left
            if (better(ram_rdata.key, left_ff.key, order_max_ff)) begin
               cand     = ram_rdata;
               cand_idx = right_w[AW-1:0];
            end else begin
               cand     = left_ff;
               cand_idx = child_ff;
            end
            ram_we = 1'b1;
            if (better(cand.key, item_ff.key, order_max_ff)) begin
               ram_wdata = cand;
               hole_in   = cand_idx;
               state_in  = ST_DN_CHK;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         order_max_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            order_max_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      left_ff   <= left_in;
      result_ff <= result_in;
      status_ff <= status_in;
      hole_ff   <= hole_in;
      child_ff  <= child_in;
      if (rsp_load) begin
         rsp_entry_ff  <= result_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_key = rsp_entry_ff.key;
   assign rsp_out_tag = rsp_entry_ff.tag;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count   = COUNT_W'(rsp_count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (status_ff == STATUS_FULL) |-> count_ff == CW'(DEPTH))
      else $error("full status with room left");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (status_ff == STATUS_EMPTY) |-> (count_ff == '0) && (result_ff == '0))
      else $error("empty status with entries or nonzero result");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) || (state_ff == ST_DONE) |-> !ram_we)
      else $error("heap write outside an operation");

endmodule

### dv/binary_heap_priority_queue_checker.sv
module binary_heap_priority_queue_checker
   import bhpq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_mode,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [TAG_W-1:0]    req_tag,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [KEY_W-1:0]    rsp_out_key,
   input  logic [TAG_W-1:0]    rsp_out_tag,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [COUNT_W-1:0]  rsp_count,
   output int                  fail_count,
   output int                  waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [TAG_W-1:0]   tag;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } heap_reply_type;

   entry_type      heap_slots [DEPTH];
   int unsigned    held = 0;
   logic           serve_max = 1'b0;
   int             errors = 0;
   heap_reply_type replies_due [$];

   initial begin
      fail_count = 0;
      waiting = 0;
   end

   function automatic bit outranks(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
      return serve_max ? (a > b) : (a < b);
   endfunction

   function automatic void swap_slots(int unsigned i, int unsigned j);
      entry_type tmp;
      tmp = heap_slots[i];
      heap_slots[i] = heap_slots[j];
      heap_slots[j] = tmp;
   endfunction

   // Apply one operation to the mirror heap and return the reply it earns.
   function automatic heap_reply_type heap_apply(logic mode, logic [KEY_W-1:0] new_key,
                                                 logic [TAG_W-1:0] new_tag);
      heap_reply_type res;
      int unsigned idx;
      int unsigned par;
      int unsigned child;
      res.key = '0;
      res.tag = '0;
      res.status = STATUS_OK;
      if (mode == MODE_INSERT) begin
         if (held >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            idx = held;
            heap_slots[idx].key = new_key;
            heap_slots[idx].tag = new_tag;
            while (idx > 0) begin
               par = (idx - 1) / 2;
               if (!outranks(heap_slots[idx].key, heap_slots[par].key)) break;
               swap_slots(idx, par);
               idx = par;
            end
            held++;
         end
      end else if (held == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.key = heap_slots[0].key;
         res.tag = heap_slots[0].tag;
         held--;
         heap_slots[0] = heap_slots[held];
         par = 0;
         child = 1;
         // Take the right child only when strictly better; equal keys stay put.
         while (child < held) begin
            if (child + 1 < held && outranks(heap_slots[child + 1].key, heap_slots[child].key))
               child++;
            if (!outranks(heap_slots[child].key, heap_slots[par].key)) break;
            swap_slots(par, child);
            par = child;
            child = 2 * par + 1;
         end
      end
      res.count = COUNT_W'(held);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      heap_reply_type due;
      if (reset) begin
         held = 0;
         serve_max = 1'b0;
         replies_due.delete();
      end else begin
         // Check the outgoing beat before queuing the incoming one.
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $error("reply beat with nothing expected: key %h tag %h status %0d count %0d",
                      rsp_out_key, rsp_out_tag, rsp_status, rsp_count);
               errors++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_out_key !== due.key) begin
                  $error("out_key expected %h got %h", due.key, rsp_out_key);
                  errors++;
               end
               if (rsp_out_tag !== due.tag) begin
                  $error("out_tag expected %h got %h", due.tag, rsp_out_tag);
                  errors++;
               end
               if (rsp_status !== due.status) begin
                  $error("status expected %0d got %0d", due.status, rsp_status);
                  errors++;
               end
               if (rsp_count !== due.count) begin
                  $error("count expected %0d got %0d", due.count, rsp_count);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            replies_due.push_back(heap_apply(req_mode, req_key, req_tag));
         if (csr_wr_en)
            serve_max = csr_wr_data;
      end
      fail_count <= errors;
      waiting <= replies_due.size();
   end

endmodule

### dv/binary_heap_priority_queue_top_tb.sv
module binary_heap_priority_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bhpq_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEM_TARGET = 1450;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic                csr_wr_data = 1'b0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_mode = MODE_INSERT;
   logic [KEY_W-1:0]    req_key = '0;
   logic [TAG_W-1:0]    req_tag = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KEY_W-1:0]    rsp_out_key;
   logic [TAG_W-1:0]    rsp_out_tag;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;

   int          fail_count;
   int          waiting;
   int          cycles = 0;
   int          items_sent = 0;
   int unsigned held = 0;
   bit          calm = 1'b0;
   bit          hold_rsp = 1'b0;

   always #5 clock = ~clock;

   binary_heap_priority_queue_top #(.DEPTH(DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_key     (req_key),
      .req_tag     (req_tag),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_key (rsp_out_key),
      .rsp_out_tag (rsp_out_tag),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count)
   );

   binary_heap_priority_queue_checker #(.DEPTH(DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_key     (req_key),
      .req_tag     (req_tag),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_key (rsp_out_key),
      .rsp_out_tag (rsp_out_tag),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count),
      .fail_count  (fail_count),
      .waiting     (waiting)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      case ($urandom_range(0, 3))
         0: return KEY_W'($urandom_range(0, 15));
         1: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               2: return {1'b1, {(KEY_W-1){1'b0}}};
               default: return {1'b0, {(KEY_W-1){1'b1}}};
            endcase
         end
         default: return KEY_W'($urandom);
      endcase
   endfunction

   // Offer one beat, hold it until taken, then optionally drop valid for a gap.
   task automatic send_item(logic mode, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                            int gap);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_key <= key;
      req_tag <= tag;
      do @(posedge clock); while (req_stall);
      if (mode == MODE_INSERT) begin
         if (held < DEPTH) held++;
      end else if (held > 0) begin
         held--;
      end
      items_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(logic mode);
      send_item(mode, rand_key(), TAG_W'($urandom_range(0, 16'hFFFF)), pick_gap());
   endtask

   // Drain every pending reply, then leave a few quiet cycles.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_order(logic serve_max);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= serve_max;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Receiver: random stall runs, calm stretches, and one long hold-off on request.
   initial begin
      int   run_len;
      logic stall_now;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall_now = 1'b1;
            run_len = HOLD_CYCLES;
         end else if (calm) begin
            stall_now = 1'b0;
            run_len = 1;
         end else begin
            stall_now = ($urandom_range(0, 2) == 0);
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(1, 4);
         end
         rsp_stall <= stall_now;
         repeat (run_len) @(posedge clock);
      end
   end

   initial begin
      int n;
      int bias;
      bit filled;
      bit pressed;
      filled = 1'b0;
      pressed = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_order(1'b0);
      send_item(MODE_REMOVE, '1, '1, pick_gap());
      send_item(MODE_INSERT, '0, '0, pick_gap());
      send_item(MODE_INSERT, '1, '1, pick_gap());
      send_item(MODE_INSERT, 32'h8000_0000, 16'h5A5A, pick_gap());
      send_item(MODE_INSERT, 32'h8000_0000, 16'hA5A5, pick_gap());
      send_item(MODE_INSERT, 32'h7FFF_FFFF, 16'h0001, pick_gap());
      send_item(MODE_INSERT, '0, 16'h8000, pick_gap());
      repeat (7) send_item(MODE_REMOVE, KEY_W'($urandom), TAG_W'($urandom), pick_gap());

      write_order(1'b1);
      send_item(MODE_INSERT, 32'h0000_0001, 16'h1234, pick_gap());
      send_item(MODE_INSERT, '1, 16'h00FF, pick_gap());
      send_item(MODE_INSERT, '1, 16'hFF00, pick_gap());
      send_item(MODE_INSERT, '0, 16'hFFFF, pick_gap());
      send_item(MODE_REMOVE, '0, '0, pick_gap());

      // Flip the order with entries still held.
      write_order(1'b0);
      repeat (2) send_item(MODE_REMOVE, '0, '0, pick_gap());
      send_item(MODE_INSERT, 32'h0000_0005, 16'h0F0F, pick_gap());
      repeat (2) send_item(MODE_REMOVE, '0, '0, pick_gap());

      while (items_sent < ITEM_TARGET) begin
         write_order(1'($urandom_range(0, 1)));
         calm = ($urandom_range(0, 4) == 0);
         if (!filled && items_sent > 400) begin
            filled = 1'b1;
            while (held < DEPTH) send_random(MODE_INSERT);
            repeat (4) send_random(MODE_INSERT);
            write_order(1'($urandom_range(0, 1)));
            while (held > 0) send_random(MODE_REMOVE);
            repeat (3) send_random(MODE_REMOVE);
         end else begin
            if (!pressed) begin
               pressed = 1'b1;
               hold_rsp = 1'b1;
            end
            n = $urandom_range(40, 160);
            bias = $urandom_range(35, 75);
            repeat (n)
               send_random(($urandom_range(0, 99) < bias) ? MODE_INSERT : MODE_REMOVE);
         end
      end
      calm = 1'b0;

      settle();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### sim.f
hw/rtl/bhpq_pkg.sv
hw/rtl/bhpq_ram.sv
hw/rtl/binary_heap_priority_queue_top.sv
dv/binary_heap_priority_queue_checker.sv
dv/binary_heap_priority_queue_top_tb.sv
